>>> rtl/core/osseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osseq_pkg: shared types and constants of the stepper sequencer
// Command codes, register indexes, reset values and the item structs.
// ----------------------------------------------------------------------------
package osseq_pkg;

  localparam int unsigned StepW   = 8;
  localparam int unsigned CprW    = 24;
  localparam int unsigned RevW    = 16;
  localparam int unsigned CycleW  = 32;
  localparam int unsigned TargetW = CprW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = CprW;

  localparam logic [StepW-1:0] FwdStepsRst = 8'd100;
  localparam logic [StepW-1:0] BwdStepsRst = 8'd90;
  localparam logic             StartDirRst = 1'b1;
  localparam logic [CprW-1:0]  CprRst      = 24'd163840;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_RESUME = 2'd2,
    MODE_STOP   = 2'd3
  } osseq_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FWD_STEPS = 2'd0,
    REG_BWD_STEPS = 2'd1,
    REG_START_DIR = 2'd2,
    REG_CPR       = 2'd3
  } osseq_reg_e;

  typedef struct packed {
    osseq_mode_e           mode;
    logic [RevW-1:0]       revolutions_q8;
  } osseq_cmd_t;

  typedef struct packed {
    logic step_level;
    logic direction_level;
    logic driver_enable;
    logic indicator_on;
    logic running;
    logic finished;
  } osseq_res_t;

endpackage

>>> rtl/core/osseq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osseq_if: channel interfaces of the stepper sequencer
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface osseq_cmd_if import osseq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      mode;
  logic [RevW-1:0] revolutions_q8;

  modport source (output valid, mode, revolutions_q8, input ready);
  modport sink   (input valid, mode, revolutions_q8, output ready);
endinterface

interface osseq_res_if;
  logic valid;
  logic ready;
  logic step_level;
  logic direction_level;
  logic driver_enable;
  logic indicator_on;
  logic running;
  logic finished;

  modport source (output valid, step_level, direction_level, driver_enable,
                  indicator_on, running, finished, input ready);
  modport sink   (input valid, step_level, direction_level, driver_enable,
                  indicator_on, running, finished, output ready);
endinterface

interface osseq_cfg_if import osseq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/oscillating_stepper_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oscillating_stepper_sequencer_top: step-pulse sequencer for a stepper driver
// Takes tick/run/resume/stop commands and returns the step, direction and
// enable line levels after each command.
// ----------------------------------------------------------------------------
// One command item is taken per clock cycle while the result channel does not
// stall, and each gives exactly one result item, passing through the input
// register and then the result register. The rate is set by the state update
// of the core: the step toggle, the leg and cycle counters and the target
// compare are all combinational, and the 24x16 target multiply on a run command
// feeds the target register directly. Configuration writes are accepted in
// every cycle and must only be issued while no command is in flight.
module oscillating_stepper_sequencer_top import osseq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  osseq_cmd_if.sink    cmd_i,
  osseq_res_if.source  res_o,
  osseq_cfg_if.sink    cfg_i
);

  osseq_cmd_t cmd_in, cmd_held;
  osseq_res_t res;
  logic       held_valid;
  logic       take;

  assign cmd_in.mode           = osseq_mode_e'(cmd_i.mode);
  assign cmd_in.revolutions_q8 = cmd_i.revolutions_q8;
  assign cfg_i.ready           = 1'b1;

  osseq_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_i.valid),
    .ready_o (cmd_i.ready),
    .cmd_i   (cmd_in),
    .take_i  (take),
    .valid_o (held_valid),
    .cmd_o   (cmd_held)
  );

  osseq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .in_valid_i  (held_valid),
    .cmd_i       (cmd_held),
    .take_o      (take),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.step_level      = res.step_level;
  assign res_o.direction_level = res.direction_level;
  assign res_o.driver_enable   = res.driver_enable;
  assign res_o.indicator_on    = res.indicator_on;
  assign res_o.running         = res.running;
  assign res_o.finished        = res.finished;

endmodule

>>> rtl/core/osseq_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osseq_in_stage: command input register
// Captures one command item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module osseq_in_stage import osseq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  osseq_cmd_t cmd_i,
  input  logic       take_i,
  output logic       valid_o,
  output osseq_cmd_t cmd_o
);

  logic       valid_q, valid_d;
  osseq_cmd_t cmd_q;

  // accept a new item when empty or whenever the held one leaves in the same cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cmd_q <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

>>> rtl/core/osseq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osseq_core: sequencer state, configuration registers and result register
// Applies one command per cycle, while the result register is not stalled, to
// the step/direction state and registers the resulting line levels.
// ----------------------------------------------------------------------------
module osseq_core import osseq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  osseq_cmd_t          cmd_i,
  output logic                take_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output osseq_res_t          res_o
);

  logic [StepW-1:0]   fwd_steps_q;
  logic [StepW-1:0]   bwd_steps_q;
  logic               start_dir_q;
  logic [CprW-1:0]    cpr_q;

  logic               step_line_q, step_line_d;
  logic               dir_line_q, dir_line_d;
  logic               phase_cw_q, phase_cw_d;
  logic [StepW-1:0]   step_cnt_q, step_cnt_d;
  logic [CycleW-1:0]  cycle_cnt_q, cycle_cnt_d;
  logic [TargetW-1:0] target_q, target_d;
  logic               run_q, run_d;
  logic               done;
  logic               res_valid_q, res_valid_d;
  osseq_res_t         res_q, res_d;
  logic [CprW+RevW-1:0] product;

  assign take_o      = in_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_d = take_o ? 1'b1 : (res_valid_q && !res_ready_i);
  assign product     = {{RevW{1'b0}}, cpr_q} * {{CprW{1'b0}}, cmd_i.revolutions_q8};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_steps_q <= FwdStepsRst;
      bwd_steps_q <= BwdStepsRst;
      start_dir_q <= StartDirRst;
      cpr_q       <= CprRst;
    end else if (cfg_valid_i) begin
      case (osseq_reg_e'(cfg_index_i))
        REG_FWD_STEPS: fwd_steps_q <= cfg_data_i[StepW-1:0];
        REG_BWD_STEPS: bwd_steps_q <= cfg_data_i[StepW-1:0];
        REG_START_DIR: start_dir_q <= cfg_data_i[0];
        REG_CPR:       cpr_q       <= cfg_data_i[CprW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_line_d = step_line_q;
    dir_line_d  = dir_line_q;
    phase_cw_d  = phase_cw_q;
    step_cnt_d  = step_cnt_q;
    cycle_cnt_d = cycle_cnt_q;
    target_d    = target_q;
    run_d       = run_q;
    done        = 1'b0;
    case (cmd_i.mode)
      MODE_TICK: begin
        if (run_q) begin
          step_line_d = !step_line_q;
          if (step_line_d) begin
            step_cnt_d = step_cnt_q + StepW'(1);
            // end of the forward leg
            if (phase_cw_d && step_cnt_d >= fwd_steps_q) begin
              dir_line_d = !dir_line_d;
              step_cnt_d = '0;
              phase_cw_d = 1'b0;
            end
            // end of the backward leg closes one cycle
            if (!phase_cw_d && step_cnt_d >= bwd_steps_q) begin
              dir_line_d  = !dir_line_d;
              step_cnt_d  = '0;
              phase_cw_d  = 1'b1;
              cycle_cnt_d = cycle_cnt_q + CycleW'(1);
              if (cycle_cnt_d >= {{(CycleW-TargetW){1'b0}}, target_q}) begin
                cycle_cnt_d = '0;
                phase_cw_d  = start_dir_q;
                run_d       = 1'b0;
                done        = 1'b1;
              end
            end
          end
        end
      end
      MODE_RUN: begin
        target_d = product[CprW+RevW-1:RevW];
        run_d    = 1'b1;
      end
      MODE_RESUME: run_d = 1'b1;
      MODE_STOP:   run_d = 1'b0;
      default: ;
    endcase
    res_d.step_level      = step_line_d;
    res_d.direction_level = dir_line_d;
    res_d.driver_enable   = run_d;
    res_d.indicator_on    = run_d;
    res_d.running         = run_d;
    res_d.finished        = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_line_q <= 1'b0;
      dir_line_q  <= 1'b1;
      phase_cw_q  <= StartDirRst;
      step_cnt_q  <= '0;
      cycle_cnt_q <= '0;
      target_q    <= '0;
      run_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take_o) begin
        step_line_q <= step_line_d;
        dir_line_q  <= dir_line_d;
        phase_cw_q  <= phase_cw_d;
        step_cnt_q  <= step_cnt_d;
        cycle_cnt_q <= cycle_cnt_d;
        target_q    <= target_d;
        run_q       <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/osseq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osseq_checker: port-level checks of the stepper sequencer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module osseq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic step_level_i,
  input logic direction_level_i,
  input logic driver_enable_i,
  input logic indicator_on_i,
  input logic running_i,
  input logic finished_i
);

  // a finishing item stops the motor
  a_finish_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && finished_i |-> !running_i && !driver_enable_i)
    else $error("finished item still shows the motor running");

  // the cycle target is only met on a rising step edge
  a_finish_on_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && finished_i |-> step_level_i)
    else $error("finished item with step line low");

  // driver enable and lamp follow the run state
  a_enable_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> driver_enable_i == running_i && indicator_on_i == running_i)
    else $error("enable or indicator differs from running");

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(step_level_i)
      && $stable(direction_level_i) && $stable(running_i) && $stable(finished_i))
    else $error("stalled result item changed");

endmodule

bind oscillating_stepper_sequencer_top osseq_checker u_osseq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .step_level_i      (res_o.step_level),
  .direction_level_i (res_o.direction_level),
  .driver_enable_i   (res_o.driver_enable),
  .indicator_on_i    (res_o.indicator_on),
  .running_i         (res_o.running),
  .finished_i        (res_o.finished)
);
